@@ rtl/core/ede_pkg.sv @@
// ----------------------------------------------------------------------------
// Expression DAG evaluator package
// Shared depths, operation codes, status codes and the request type of the
// iterative binary64 arithmetic unit.
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam int EDE_NODE_DEPTH  = 1024;
    localparam int EDE_PARAM_DEPTH = 256;

    // Command codes of an input transaction.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_NODE  = 1'b1;

    // Node operation codes.
    localparam logic [2:0] OP_CONST = 3'd0;
    localparam logic [2:0] OP_PARAM = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUB   = 3'd3;
    localparam logic [2:0] OP_MUL   = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;
    localparam logic [2:0] OP_NEG   = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISSING   = 2'd1;
    localparam logic [1:0] ST_DIVZERO   = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL,
        FOP_DIV
    } t_fop;

    typedef struct packed {
        logic start;
        t_fop op;
    } t_fpu_req;

endpackage

@@ rtl/core/ede_fpu.sv @@
// ----------------------------------------------------------------------------
// Iterative binary64 arithmetic unit
// Add, subtract, multiply and divide with round to nearest even, one step a
// cycle for normalisation, multiplication and division.
// ----------------------------------------------------------------------------
module ede_fpu import ede_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fpu_req    i_req,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_result
);

    localparam logic [6:0]  MUL_LAST  = 7'd52;
    localparam logic [6:0]  DIV_LAST  = 7'd63;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEF_NAN   = 64'hFFF8_0000_0000_0000;

    typedef enum logic [3:0] {
        F_IDLE, F_UNPACK, F_PRENORM, F_SWAP, F_ALIGN, F_SUM,
        F_MUL, F_DIV, F_NORM, F_DENORM, F_ROUND
    } t_fstate;

    function automatic logic [63:0] shr_jam(input logic [63:0] x, input logic [13:0] amt);
        logic [63:0] mask;
        logic [63:0] y;
        mask = ~(64'hFFFF_FFFF_FFFF_FFFF << amt[5:0]);
        y    = x >> amt[5:0];
        if (amt >= 14'd64) begin
            return {63'b0, |x};
        end
        return {y[63:1], y[0] | (|(x & mask))};
    endfunction

    function automatic logic signed [13:0] unbias(input logic [10:0] e);
        return $signed({3'b000, (e == 11'd0) ? 11'd1 : e}) - 14'sd1023;
    endfunction

    t_fstate              r_state;
    t_fop                 r_op;
    logic [63:0]          r_a, r_b, r_res, r_m;
    logic                 r_sa, r_sb, r_sx, r_sticky, r_den, r_done;
    logic [52:0]          r_ma, r_mb;
    logic signed [13:0]   r_ea, r_eb, r_e;
    logic [105:0]         r_p;
    logic [54:0]          r_rem;
    logic [6:0]           r_cnt;

    logic        w_a_nan, w_b_nan, w_a_inf, w_b_inf, w_a_zero, w_b_zero, w_sbe, w_sxm;
    logic        w_spec;
    logic [63:0] w_spec_res;
    logic [53:0] w_psum;
    logic [105:0] w_pnext;
    logic        w_ge;
    logic [54:0] w_rdiff, w_rnext;
    logic [64:0] w_xb, w_xs, w_s;
    logic signed [13:0] w_bias;
    logic [13:0] w_den_amt;
    logic        w_inc;
    logic [62:0] w_mag;

    assign w_a_nan  = (&r_a[62:52]) && (|r_a[51:0]);
    assign w_b_nan  = (&r_b[62:52]) && (|r_b[51:0]);
    assign w_a_inf  = (&r_a[62:52]) && !(|r_a[51:0]);
    assign w_b_inf  = (&r_b[62:52]) && !(|r_b[51:0]);
    assign w_a_zero = ~|r_a[62:0];
    assign w_b_zero = ~|r_b[62:0];
    assign w_sbe    = (r_op == FOP_SUB) ? ~r_b[63] : r_b[63];
    assign w_sxm    = r_a[63] ^ r_b[63];

    // Operands that settle the result without arithmetic.
    always_comb begin
        w_spec     = 1'b1;
        w_spec_res = DEF_NAN;
        if (w_a_nan) begin
            w_spec_res = r_a | QUIET_BIT;
        end else if (w_b_nan) begin
            w_spec_res = r_b | QUIET_BIT;
        end else begin
            case (r_op)
                FOP_ADD, FOP_SUB: begin
                    if (w_a_inf && w_b_inf && (r_a[63] != w_sbe)) w_spec_res = DEF_NAN;
                    else if (w_a_inf) w_spec_res = r_a;
                    else if (w_b_inf) w_spec_res = {w_sbe, 11'h7FF, 52'b0};
                    else w_spec = 1'b0;
                end
                FOP_MUL: begin
                    if ((w_a_inf && w_b_zero) || (w_b_inf && w_a_zero)) w_spec_res = DEF_NAN;
                    else if (w_a_inf || w_b_inf) w_spec_res = {w_sxm, 11'h7FF, 52'b0};
                    else if (w_a_zero || w_b_zero) w_spec_res = {w_sxm, 63'b0};
                    else w_spec = 1'b0;
                end
                default: begin
                    if (w_a_inf && w_b_inf) w_spec_res = DEF_NAN;
                    else if (w_a_inf) w_spec_res = {w_sxm, 11'h7FF, 52'b0};
                    else if (w_b_inf || w_a_zero) w_spec_res = {w_sxm, 63'b0};
                    else w_spec = 1'b0;
                end
            endcase
        end
    end

    assign w_psum    = {1'b0, r_p[105:53]} + (r_p[0] ? {1'b0, r_mb} : 54'd0);
    assign w_pnext   = {w_psum, r_p[52:1]};
    assign w_ge      = r_rem >= {2'b00, r_mb};
    assign w_rdiff   = w_ge ? (r_rem - {2'b00, r_mb}) : r_rem;
    assign w_rnext   = {w_rdiff[53:0], 1'b0};
    assign w_xb      = {1'b0, r_ma, 11'b0};
    assign w_xs      = {1'b0, r_m};
    assign w_s       = (r_sa == r_sb) ? (w_xb + w_xs) : (w_xb - w_xs);
    assign w_bias    = r_e + 14'sd1023;
    assign w_den_amt = $unsigned(-14'sd1022 - r_e);
    assign w_inc     = r_m[10] & ((|r_m[9:0]) | r_sticky | r_m[11]);
    assign w_mag     = {(r_den ? 11'd0 : w_bias[10:0]), r_m[62:11]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_state <= F_UNPACK;
                    end
                end
                F_UNPACK: begin
                    if (w_spec) begin
                        r_res   <= w_spec_res;
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else begin
                        r_ma     <= {|r_a[62:52], r_a[51:0]};
                        r_mb     <= {|r_b[62:52], r_b[51:0]};
                        r_ea     <= unbias(r_a[62:52]);
                        r_eb     <= unbias(r_b[62:52]);
                        r_sa     <= r_a[63];
                        r_sb     <= w_sbe;
                        r_sx     <= w_sxm;
                        r_sticky <= 1'b0;
                        r_den    <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= (r_op == FOP_ADD || r_op == FOP_SUB) ? F_SWAP : F_PRENORM;
                    end
                end
                F_PRENORM: begin
                    if (!r_ma[52]) begin
                        r_ma <= {r_ma[51:0], 1'b0};
                        r_ea <= r_ea - 14'sd1;
                    end
                    if (!r_mb[52]) begin
                        r_mb <= {r_mb[51:0], 1'b0};
                        r_eb <= r_eb - 14'sd1;
                    end
                    if (r_ma[52] && r_mb[52]) begin
                        r_p     <= {53'b0, r_ma};
                        r_rem   <= {2'b00, r_ma};
                        r_m     <= '0;
                        r_state <= (r_op == FOP_MUL) ? F_MUL : F_DIV;
                    end
                end
                F_MUL: begin
                    r_p   <= w_pnext;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == MUL_LAST) begin
                        r_m      <= w_pnext[105:42];
                        r_sticky <= |w_pnext[41:0];
                        r_e      <= r_ea + r_eb + 14'sd1;
                        r_state  <= F_NORM;
                    end
                end
                F_DIV: begin
                    r_m   <= {r_m[62:0], w_ge};
                    r_rem <= w_rnext;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_sticky <= |w_rnext;
                        r_e      <= r_ea - r_eb;
                        r_state  <= F_NORM;
                    end
                end
                F_SWAP: begin
                    if (r_a[62:0] >= r_b[62:0]) begin
                        r_sx <= r_sa;
                    end else begin
                        r_ma <= r_mb;
                        r_mb <= r_ma;
                        r_ea <= r_eb;
                        r_eb <= r_ea;
                        r_sa <= r_sb;
                        r_sb <= r_sa;
                        r_sx <= r_sb;
                    end
                    r_state <= F_ALIGN;
                end
                F_ALIGN: begin
                    r_m     <= shr_jam({r_mb, 11'b0}, $unsigned(r_ea - r_eb));
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    if (w_s == 65'd0) begin
                        r_res   <= {r_sa & r_sb, 63'b0};
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else begin
                        if (w_s[64]) begin
                            r_m <= {w_s[64:2], w_s[1] | w_s[0]};
                            r_e <= r_ea + 14'sd1;
                        end else begin
                            r_m <= w_s[63:0];
                            r_e <= r_ea;
                        end
                        r_state <= F_NORM;
                    end
                end
                F_NORM: begin
                    if (!r_m[63]) begin
                        r_m <= {r_m[62:0], 1'b0};
                        r_e <= r_e - 14'sd1;
                    end else begin
                        r_state <= F_DENORM;
                    end
                end
                F_DENORM: begin
                    if (r_e > 14'sd1023) begin
                        r_res   <= {r_sx, 11'h7FF, 52'b0};
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else begin
                        if (r_e < -14'sd1022) begin
                            r_m   <= shr_jam(r_m, w_den_amt);
                            r_den <= 1'b1;
                        end
                        r_state <= F_ROUND;
                    end
                end
                F_ROUND: begin
                    r_res   <= {r_sx, w_mag + {62'b0, w_inc}};
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ rtl/core/expression_dag_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// Expression DAG evaluator
// Evaluates straight-line binary64 expression graphs node by node and
// returns the value of the last node with a status.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and stalls its input while a node
// is being evaluated. A parameter write is absorbed in the cycle it is
// accepted. A constant node passes through the decode, write and finish
// states; a parameter node also reads the parameter store, and a negate node
// its operand. Add and subtract go through the shared iterative binary64
// unit, with one normalisation step for each bit of cancellation. Multiply
// and divide run through the one-bit-per-cycle multiply and divide loops of
// that unit, after any subnormal operand has been normalised.
// A last node adds the result transaction, which waits in an output register;
// if that register is still full the block holds until it drains.

module expression_dag_evaluator_top import ede_pkg::*; #(
    parameter int NODE_DEPTH  = EDE_NODE_DEPTH,
    parameter int PARAM_DEPTH = EDE_PARAM_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_value_bits,
    input  logic [7:0]  i_parameter_id,
    input  logic        i_parameter_known,
    input  logic [9:0]  i_left_index,
    input  logic [9:0]  i_right_index,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_bits,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int NW         = $clog2(NODE_DEPTH);
    localparam int CW         = NW + 1;
    // Parameter identifiers are eight bits wide, so no more entries are reachable.
    localparam int PARAM_USED = (PARAM_DEPTH < 256) ? PARAM_DEPTH : 256;
    localparam int PW         = (PARAM_USED > 1) ? $clog2(PARAM_USED) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_PGET, S_RDB, S_OPB, S_FPU, S_WR, S_FIN
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_cnt;
    logic [1:0]        r_err;
    logic              r_env;
    logic [2:0]        r_op;
    logic [63:0]       r_vbits, r_a, r_v, r_nrd, r_prd, r_obits;
    logic [7:0]        r_pid;
    logic [9:0]        r_li, r_ri;
    logic              r_last, r_ovalid;
    logic [1:0]        r_ostat;
    logic [PARAM_USED-1:0] r_pvalid;

    logic [63:0] r_node_mem [NODE_DEPTH];
    logic [63:0] r_param_mem [PARAM_USED];

    logic          w_in_acc, w_pwrite;
    logic [31:0]   w_in_pid32, w_pid32, w_li32, w_ri32, w_cnt32;
    logic [PW-1:0] w_in_pidx, w_pidx;
    logic [NW-1:0] w_naddr;
    logic          w_full, w_li_ok, w_ri_ok, w_pid_ok, w_divzero;
    t_fpu_req      w_fpu_req;
    logic          w_fpu_done;
    logic [63:0]   w_fpu_res;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_in_pid32 = 32'(i_parameter_id);
    assign w_in_pidx  = w_in_pid32[PW-1:0];
    assign w_pwrite   = w_in_acc && (i_command == CMD_WRITE) &&
                        (w_in_pid32 < 32'(PARAM_DEPTH));

    assign w_pid32  = 32'(r_pid);
    assign w_pidx   = w_pid32[PW-1:0];
    assign w_li32   = 32'(r_li);
    assign w_ri32   = 32'(r_ri);
    assign w_cnt32  = 32'(r_cnt);
    assign w_full   = r_cnt >= CW'(NODE_DEPTH);
    assign w_li_ok  = w_li32 < w_cnt32;
    assign w_ri_ok  = w_ri32 < w_cnt32;
    assign w_pid_ok = r_env && (w_pid32 < 32'(PARAM_DEPTH)) && r_pvalid[w_pidx];
    // Either sign of zero as divisor; a NaN is not zero.
    assign w_divzero = (r_op == OP_DIV) && (r_nrd[62:0] == 63'd0);

    // The left operand is fetched while decoding, the right one in S_RDB.
    assign w_naddr = (r_state == S_DEC) ? w_li32[NW-1:0] : w_ri32[NW-1:0];

    always_comb begin
        w_fpu_req.start = (r_state == S_OPB) && !w_divzero;
        case (r_op)
            OP_SUB:  w_fpu_req.op = FOP_SUB;
            OP_MUL:  w_fpu_req.op = FOP_MUL;
            OP_DIV:  w_fpu_req.op = FOP_DIV;
            default: w_fpu_req.op = FOP_ADD;
        endcase
    end

    ede_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_fpu_req),
        .i_a      (r_a),
        .i_b      (r_nrd),
        .o_done   (w_fpu_done),
        .o_result (w_fpu_res)
    );

    // Node value store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_node_mem[r_cnt[NW-1:0]] <= r_v;
        end
        r_nrd <= r_node_mem[w_naddr];
    end

    // Parameter value store; the known bits live in flip-flops below.
    always_ff @(posedge i_clk) begin
        if (w_pwrite) begin
            r_param_mem[w_in_pidx] <= i_value_bits;
        end
        r_prd <= r_param_mem[w_pidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
        end else if (w_pwrite) begin
            r_pvalid[w_in_pidx] <= i_parameter_known;
        end
    end

    // Node sequencer. A failing node still takes its slot; after the first
    // failure later nodes are only counted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_err    <= ST_OK;
            r_env    <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            // While a last node finishes, the output register is reloaded
            // below instead of being emptied here.
            if (r_ovalid && !i_stall && !(r_state == S_FIN && r_last)) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_env <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_command == CMD_NODE)) begin
                        r_op    <= i_op;
                        r_vbits <= i_value_bits;
                        r_pid   <= i_parameter_id;
                        r_li    <= i_left_index;
                        r_ri    <= i_right_index;
                        r_last  <= i_last;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (w_full) begin
                        // Store overflow: the count saturates.
                        if (r_err == ST_OK) begin
                            r_err <= ST_MALFORMED;
                        end
                        r_state <= S_FIN;
                    end else if (r_err != ST_OK) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_FIN;
                    end else begin
                        unique case (r_op) inside
                            OP_CONST: begin
                                r_v     <= r_vbits;
                                r_state <= S_WR;
                            end
                            OP_PARAM: begin
                                if (w_pid_ok) begin
                                    r_state <= S_PGET;
                                end else begin
                                    r_err   <= ST_MISSING;
                                    r_cnt   <= r_cnt + CW'(1);
                                    r_state <= S_FIN;
                                end
                            end
                            OP_NEG: begin
                                if (w_li_ok) begin
                                    r_state <= S_RDB;
                                end else begin
                                    r_err   <= ST_MALFORMED;
                                    r_cnt   <= r_cnt + CW'(1);
                                    r_state <= S_FIN;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (w_li_ok && w_ri_ok) begin
                                    r_state <= S_RDB;
                                end else begin
                                    r_err   <= ST_MALFORMED;
                                    r_cnt   <= r_cnt + CW'(1);
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                                r_err   <= ST_MALFORMED;
                                r_cnt   <= r_cnt + CW'(1);
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_PGET: begin
                    r_v     <= r_prd;
                    r_state <= S_WR;
                end
                S_RDB: begin
                    r_a <= r_nrd;
                    if (r_op == OP_NEG) begin
                        r_v     <= r_nrd ^ SIGN_MASK;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_OPB;
                    end
                end
                S_OPB: begin
                    if (w_divzero) begin
                        r_err   <= ST_DIVZERO;
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FPU;
                    end
                end
                S_FPU: begin
                    if (w_fpu_done) begin
                        r_v     <= w_fpu_res;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_obits  <= (r_err == ST_OK) ? r_v : 64'd0;
                        r_ostat  <= r_err;
                        r_cnt    <= '0;
                        r_err    <= ST_OK;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_result_bits = r_obits;
    assign o_status      = r_ostat;
    assign o_cfg_ready   = 1'b1;

    // A new result transaction only appears after finishing a last node.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN && r_last))
        else $error("result appeared without a finished last node");

    // A failed expression never reports a value.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_result_bits == 64'd0))
        else $error("nonzero result with failure status");

    // The node count saturates at the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NODE_DEPTH))
        else $error("node count beyond store depth");

    // The arithmetic unit only completes while the sequencer waits for it.
    a_fpu_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fpu_done |-> (r_state == S_FPU))
        else $error("arithmetic completion outside wait state");

endmodule

@@ bench/expression_dag_evaluator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression DAG evaluator testbench
// Sends parameter writes and expression nodes to the evaluator and checks
// every result transaction against a local binary64 predictor. A short table
// of directed transactions comes first. Random expressions follow, in three
// phases of varied idling and parameter environment, then a store overflow.
// ----------------------------------------------------------------------------
module expression_dag_evaluator_top_tb;
    import ede_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 250;   // slowest node with subnormal operands
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 85;

    typedef struct {
        logic        command;
        logic [2:0]  op;
        logic [63:0] value_bits;
        logic [7:0]  parameter_id;
        logic        parameter_known;
        logic [9:0]  left_index;
        logic [9:0]  right_index;
        logic        last;
    } node_item_t;

    typedef struct {
        logic [63:0] result_bits;
        logic [1:0]  status;
    } eval_result_t;

    typedef struct {
        node_item_t   item;
        bit           typed;
        eval_result_t result;
    } directed_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_command;
    logic [2:0]  i_op;
    logic [63:0] i_value_bits;
    logic [7:0]  i_parameter_id;
    logic        i_parameter_known;
    logic [9:0]  i_left_index;
    logic [9:0]  i_right_index;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_bits;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    expression_dag_evaluator_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_op              (i_op),
        .i_value_bits      (i_value_bits),
        .i_parameter_id    (i_parameter_id),
        .i_parameter_known (i_parameter_known),
        .i_left_index      (i_left_index),
        .i_right_index     (i_right_index),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_bits     (o_result_bits),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    // Predictor state: a private copy of the evaluator's tables and counters.
    logic [63:0] pred_node_value  [EDE_NODE_DEPTH];
    logic [63:0] pred_param_value [EDE_PARAM_DEPTH];
    bit          pred_param_known [EDE_PARAM_DEPTH];
    int unsigned pred_node_count;
    logic [1:0]  pred_first_error;
    bit          pred_environment;

    // Results still owed by the evaluator, oldest first.
    eval_result_t pending_results[$];

    int unsigned mismatch_count;
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    bit          hold_request;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned items_sent;

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Generous fixed limit on the whole run.
    initial begin
        #(64'd5_000_000 * 2 * CLK_HALF);
        $display("expression_dag_evaluator_top: mismatch");
        $finish;
    end

    // Works out the value of one node as the evaluator should see it.
    function automatic logic [1:0] evaluate_node(input node_item_t it,
                                                 input int unsigned self,
                                                 output logic [63:0] value);
        bit  binary;
        real lhs;
        real rhs;
        binary = (it.op == OP_ADD || it.op == OP_SUB || it.op == OP_MUL ||
                  it.op == OP_DIV);
        value  = '0;
        if (it.op == OP_CONST) begin
            value = it.value_bits;
            return ST_OK;
        end
        if (it.op == OP_PARAM) begin
            if (!pred_environment || !pred_param_known[it.parameter_id])
                return ST_MISSING;
            value = pred_param_value[it.parameter_id];
            return ST_OK;
        end
        if (it.op > OP_NEG)
            return ST_MALFORMED;
        if (it.left_index >= self || (binary && it.right_index >= self))
            return ST_MALFORMED;
        if (it.op == OP_NEG) begin
            value = pred_node_value[it.left_index] ^ SIGN_MASK;
            return ST_OK;
        end
        lhs = $bitstoreal(pred_node_value[it.left_index]);
        rhs = $bitstoreal(pred_node_value[it.right_index]);
        case (it.op)
            OP_ADD: value = $realtobits(lhs + rhs);
            OP_SUB: value = $realtobits(lhs - rhs);
            OP_MUL: value = $realtobits(lhs * rhs);
            default: begin
                // Either sign of zero counts as a zero divisor; NaN does not.
                if (rhs == 0.0)
                    return ST_DIVZERO;
                value = $realtobits(lhs / rhs);
            end
        endcase
        return ST_OK;
    endfunction

    // Advances the predictor by one accepted transaction.
    function automatic bit predict_transaction(input node_item_t it,
                                               output eval_result_t res);
        logic [63:0] value;
        logic [1:0]  st;
        int unsigned self;
        self = pred_node_count;
        res  = '{default: '0};
        if (it.command == CMD_WRITE) begin
            pred_param_value[it.parameter_id] = it.value_bits;
            pred_param_known[it.parameter_id] = it.parameter_known;
            return 1'b0;
        end
        if (self >= EDE_NODE_DEPTH) begin
            if (pred_first_error == ST_OK)
                pred_first_error = ST_MALFORMED;
        end else begin
            if (pred_first_error == ST_OK) begin
                st = evaluate_node(it, self, value);
                if (st == ST_OK)
                    pred_node_value[self] = value;
                else
                    pred_first_error = st;
            end
            pred_node_count = self + 1;
        end
        if (!it.last)
            return 1'b0;
        if (pred_first_error == ST_OK && self < EDE_NODE_DEPTH)
            res.result_bits = pred_node_value[self];
        res.status       = pred_first_error;
        pred_node_count  = 0;
        pred_first_error = ST_OK;
        return 1'b1;
    endfunction

    // Offers one transaction and waits for it to be taken. A typed result,
    // where given, stands in for the predictor's own.
    task automatic send_transaction(input node_item_t it, input bit typed,
                                    input eval_result_t typed_result);
        eval_result_t res;
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_command         = it.command;
        i_op              = it.op;
        i_value_bits      = it.value_bits;
        i_parameter_id    = it.parameter_id;
        i_parameter_known = it.parameter_known;
        i_left_index      = it.left_index;
        i_right_index     = it.right_index;
        i_last            = it.last;
        do
            @(posedge i_clk);
        while (o_stall);
        if (predict_transaction(it, res))
            pending_results.insert(pending_results.size(),
                                   typed ? typed_result : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Lets the evaluator empty out, including any node that owes no result.
    task automatic wait_until_idle();
        i_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_environment(input bit present);
        i_cfg_valid = 1'b1;
        i_cfg_data  = present;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        pred_environment = present;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly ordinary numbers, with zeros, infinities, NaNs, subnormals and
    // raw bit patterns mixed in.
    function automatic logic [63:0] random_double();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(19))
            0, 1: ;
            2, 3: bits = {bits[63], 63'd0};
            4:    bits = {bits[63], 11'h7FF, 52'd0};
            5:    bits = {bits[63], 11'h7FF, bits[51:0] | 52'd1};
            6:    bits = {bits[63], 11'd0, bits[51:0]};
            default:
                bits[62:52] = 11'(1023 - 20 + $urandom_range(40));
        endcase
        return bits;
    endfunction

    function automatic node_item_t blank_item();
        node_item_t it;
        it = '{default: '0};
        it.command      = CMD_NODE;
        it.left_index   = 10'($urandom);
        it.right_index  = 10'($urandom);
        it.parameter_id = 8'($urandom);
        it.value_bits   = random_double();
        return it;
    endfunction

    // A random expression, mostly well formed, with occasional bad operands,
    // unknown ops, unknown parameters and interleaved parameter writes.
    task automatic send_random_expression(input int unsigned len);
        node_item_t   it;
        eval_result_t none;
        int unsigned  roll;
        none = '{default: '0};
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
                it                 = blank_item();
                it.command         = CMD_WRITE;
                it.op              = 3'($urandom);
                it.last            = 1'($urandom);
                it.parameter_known = ($urandom_range(4) != 0);
                if ($urandom_range(3) != 0)
                    it.parameter_id = 8'($urandom_range(15));
                send_transaction(it, 1'b0, none);
            end
            it      = blank_item();
            it.last = (k == len - 1);
            roll    = $urandom_range(99);
            if (roll < 2)
                it.op = 3'd7;
            else if (k == 0 || roll < 30)
                it.op = ($urandom_range(1) != 0) ? OP_PARAM : OP_CONST;
            else
                it.op = 3'(OP_ADD + $urandom_range(4));
            if ($urandom_range(3) != 0)
                it.parameter_id = 8'($urandom_range(15));
            if (k > 0 && $urandom_range(99) >= 3) begin
                it.left_index  = 10'($urandom_range(k - 1));
                it.right_index = 10'($urandom_range(k - 1));
            end
            send_transaction(it, 1'b0, none);
        end
    endtask

    // The receiver idles at random, and once holds off for a long stretch so
    // that the output register fills and the evaluator stalls its input.
    always @(negedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall   = 1'b1;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Every accepted result transaction is checked against the oldest one owed.
    always @(posedge i_clk) begin
        eval_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: bits %h status %0d",
                             o_result_bits, o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_result_bits !== want.result_bits || o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result differs: expected %h/%0d, got %h/%0d",
                                 want.result_bits, want.status, o_result_bits,
                                 o_status);
                end
            end
        end
    end

    directed_row_t directed[$];

    // Appends one row to the directed table.
    function automatic void row(input logic cmd, input logic [2:0] op,
                                input logic [63:0] bits,
                                input logic [7:0] pid, input logic known,
                                input logic [9:0] li, input logic [9:0] ri,
                                input logic last, input bit typed,
                                input logic [63:0] want_bits,
                                input logic [1:0] want_status);
        directed_row_t r;
        r.item   = '{cmd, op, bits, pid, known, li, ri, last};
        r.typed  = typed;
        r.result = '{want_bits, want_status};
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        localparam logic [63:0] ONE   = 64'h3FF0_0000_0000_0000;
        localparam logic [63:0] TWO   = 64'h4000_0000_0000_0000;
        localparam logic [63:0] THREE = 64'h4008_0000_0000_0000;
        localparam logic [63:0] NAN_Q = 64'h7FF8_0000_0000_0000;
        localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
        node_item_t   it;
        int unsigned  target;

        mismatch_count    = 0;
        items_sent        = 0;
        send_gap_pct      = 0;
        recv_stall_pct    = 0;
        hold_request      = 1'b0;
        hold_done         = 1'b0;
        hold_left         = 0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_command         = CMD_WRITE;
        i_op              = OP_CONST;
        i_value_bits      = '0;
        i_parameter_id    = '0;
        i_parameter_known = 1'b0;
        i_left_index      = '0;
        i_right_index     = '0;
        i_last            = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = 1'b0;
        pred_node_count   = 0;
        pred_first_error  = ST_OK;
        pred_environment  = 1'b1;
        foreach (pred_param_known[i]) pred_param_known[i] = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extremes, every op and every kind of failure.
        row(CMD_WRITE, OP_CONST, ONE, 8'd0, 1'b1, 10'd0, 10'd0,
            1'b0, 0, 0, ST_OK);
        row(CMD_WRITE, OP_NEG, ONES, 8'd255, 1'b0, 10'h3FF,
            10'h3FF, 1'b1, 0, 0, ST_OK);
        // A constant passes its bits through; both indices are ignored.
        row(CMD_NODE, OP_CONST, ONES, 8'd255, 1'b1, 10'h3FF,
            10'h3FF, 1'b1, 1, ONES, ST_OK);
        row(CMD_NODE, OP_PARAM, 0, 8'd0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_PARAM, 0, 8'd0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_ADD, 0, 0, 0, 10'd0, 10'd1, 1'b1,
            1, TWO, ST_OK);
        // Parameter whose known bit is clear.
        row(CMD_NODE, OP_PARAM, ONES, 8'd255, 1, 0, 0, 1'b1,
            1, 0, ST_MISSING);
        // Divide by negative zero.
        row(CMD_NODE, OP_CONST, ONE, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_CONST, SIGN_MASK, 0, 0, 0, 0, 0,
            0, 0, ST_OK);
        row(CMD_NODE, OP_DIV, 0, 0, 0, 10'd0, 10'd1, 1'b1,
            1, 0, ST_DIVZERO);
        // Subtract, multiply and negate in one chain.
        row(CMD_NODE, OP_CONST, THREE, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_CONST, TWO, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_SUB, 0, 0, 0, 10'd0, 10'd1, 0,
            0, 0, ST_OK);
        row(CMD_NODE, OP_MUL, 0, 0, 0, 10'd2, 10'd1, 0,
            0, 0, ST_OK);
        row(CMD_NODE, OP_NEG, 0, 0, 0, 10'd3, 10'h3FF, 1'b1,
            1, 64'hC000_0000_0000_0000, ST_OK);
        // Operand that does not point below the node itself.
        row(CMD_NODE, OP_CONST, ONE, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_ADD, 0, 0, 0, 10'd1, 10'd0, 1'b1,
            1, 0, ST_MALFORMED);
        // Unknown op, then a node that must not clear the first failure.
        row(CMD_NODE, 3'd7, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_CONST, ONE, 0, 0, 0, 0, 1'b1,
            1, 0, ST_MALFORMED);
        // A NaN divisor is not zero and divides normally.
        row(CMD_NODE, OP_CONST, NAN_Q, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_CONST, ONE, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        row(CMD_NODE, OP_DIV, 0, 0, 0, 10'd1, 10'd0, 1'b1,
            0, 0, ST_OK);

        write_environment(1'b1);
        foreach (directed[i])
            send_transaction(directed[i].item, directed[i].typed, directed[i].result);

        // Random phases: idling pattern and environment change between them.
        for (int ph = 0; ph < 3; ph++) begin
            wait_until_idle();
            write_environment(ph != 1);
            send_gap_pct   = (ph == 0) ? 22 : (ph == 1) ? 51 : 0;
            recv_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 22 : 0;
            target         = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if (ph == 2 && !hold_request && items_sent + 40 < target)
                    hold_request = 1'b1;
                if ($urandom_range(60) == 0)
                    wait_until_idle();
                send_random_expression($urandom_range(1, 12));
            end
        end

        // Store overflow: one node more than the store holds.
        for (int k = 0; k <= EDE_NODE_DEPTH; k++) begin
            it      = blank_item();
            it.op   = OP_CONST;
            it.last = (k == EDE_NODE_DEPTH);
            send_transaction(it, it.last, '{64'd0, ST_MALFORMED});
        end

        wait_until_idle();
        if (mismatch_count == 0)
            $display("expression_dag_evaluator_top: match");
        else
            $display("expression_dag_evaluator_top: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ede_pkg.sv
rtl/core/ede_fpu.sv
rtl/core/expression_dag_evaluator_top.sv
bench/expression_dag_evaluator_top_tb.sv
